@@ hdl/srfr_pkg.sv @@
// Shared types and constants for the servo reply frame receiver.
package srfr_pkg;

  localparam int MAX_FRAME_BYTES = 10;
  localparam int IDX_W = 4;

  localparam logic [IDX_W-1:0] LEN_MIN = 4'd2;
  localparam logic [IDX_W-1:0] LEN_MAX = 4'd8;
  localparam logic [IDX_W-1:0] LEN_POS = 4'd2;

  // frame byte positions that reach an output
  localparam int FIRST_KEPT = 3;
  localparam int LAST_KEPT  = 7;
  localparam int CMD_POS    = 3;
  localparam int BATT_LO    = 4;
  localparam int BATT_HI    = 5;
  localparam int POS_LO     = 6;
  localparam int POS_HI     = 7;

  localparam int QDEPTH = 2;

  localparam logic [1:0] REG_HEADER   = 2'd0;
  localparam logic [1:0] REG_BATT_CMD = 2'd1;
  localparam logic [1:0] REG_POS_CMD  = 2'd2;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  typedef struct packed {
    logic       consume;
    logic       hdr;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [7:0] battery_command;
    logic [7:0] position_command;
  } cmd_cfg_t;

  // frame_ready in bit 0
  typedef struct packed {
    logic [15:0] servo_position;
    logic [15:0] battery_volt;
    logic        frame_dropped;
    logic        frame_latched;
    logic        frame_ready;
  } result_t;

endpackage

@@ hdl/srfr_front.sv @@
// Front end: request classification and a two-entry queue to the back end.
module srfr_front import srfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte
  input  logic       s_tuser,   // req_type
  input  logic [7:0] header_byte,
  input  logic       pop,
  output logic       q_valid,
  output op_t        q_op
);

  op_t        mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        op_in;

  assign s_tready = (count != 2'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_op     = mem[rd_ptr];

  assign op_in.consume = (s_tuser == REQ_CONSUME);
  assign op_in.hdr     = (s_tdata == header_byte);
  assign op_in.data    = s_tdata;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hdl/srfr_back.sv @@
// Back end: deframing, frame latch, decode on consume, output register.
module srfr_back import srfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  op_t         q_op,
  output logic        pop,
  input  cmd_cfg_t    cmds,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // frame_ready, frame_latched, frame_dropped,
                                // battery_volt[15:0], servo_position[15:0], zero pad
);

  logic             found;
  logic             hseen;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] len;
  logic             ready;
  logic [15:0]      batt;
  logic [15:0]      pos;
  logic [7:0]       staging [FIRST_KEPT:LAST_KEPT];
  logic [7:0]       latched [FIRST_KEPT:LAST_KEPT];
  result_t          res;

  logic             found_next;
  logic             hseen_next;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] len_next;
  logic             ready_next;
  logic [15:0]      batt_next;
  logic [15:0]      pos_next;
  logic [IDX_W-1:0] widx;
  logic             st_we;
  logic             lat;
  logic             drp;
  logic             step;

  assign step = q_valid && (!m_tvalid || m_tready);
  assign pop  = step;

  always_comb begin
    found_next = found;
    hseen_next = hseen;
    idx_next   = idx;
    len_next   = len;
    ready_next = ready;
    batt_next  = batt;
    pos_next   = pos;
    widx       = idx;
    st_we      = 1'b0;
    lat        = 1'b0;
    drp        = 1'b0;
    if (!q_op.consume) begin
      if (!found_next) begin
        if (q_op.hdr) begin
          if (hseen_next) begin
            hseen_next = 1'b0;
            found_next = 1'b1;
            idx_next   = 4'd1;
          end else begin
            hseen_next = 1'b1;
          end
        end else begin
          idx_next   = '0;
          hseen_next = 1'b0;
        end
      end
      if (found_next) begin
        widx  = idx_next;
        st_we = (idx_next < IDX_W'(MAX_FRAME_BYTES));
        if (idx_next == LEN_POS) begin
          if (q_op.data < 8'(LEN_MIN) || q_op.data > 8'(LEN_MAX)) begin
            len_next   = LEN_MIN;
            found_next = 1'b0;
          end else begin
            len_next = q_op.data[IDX_W-1:0];
          end
        end
        idx_next = idx_next + 4'd1;
        if (idx_next == len_next + 4'd2) begin
          if (!ready_next) begin
            ready_next = 1'b1;
            lat        = 1'b1;
          end else begin
            drp = 1'b1;
          end
          found_next = 1'b0;
        end
      end
    end else if (ready) begin
      ready_next = 1'b0;
      if (latched[CMD_POS] == cmds.battery_command) begin
        batt_next = {latched[BATT_HI], latched[BATT_LO]};
      end else if (latched[CMD_POS] == cmds.position_command) begin
        pos_next = {latched[POS_HI], latched[POS_LO]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = FIRST_KEPT; k <= LAST_KEPT; k++) begin
        if (st_we && widx == IDX_W'(k)) begin
          staging[k] <= q_op.data;
        end
      end
      res.frame_ready    <= ready_next;
      res.frame_latched  <= lat;
      res.frame_dropped  <= drp;
      res.battery_volt   <= batt_next;
      res.servo_position <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      hseen    <= 1'b0;
      idx      <= '0;
      len      <= LEN_MIN;
      ready    <= 1'b0;
      batt     <= '0;
      pos      <= '0;
      m_tvalid <= 1'b0;
      for (int k = FIRST_KEPT; k <= LAST_KEPT; k++) begin
        latched[k] <= '0;
      end
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (step) begin
        found    <= found_next;
        hseen    <= hseen_next;
        idx      <= idx_next;
        len      <= len_next;
        ready    <= ready_next;
        batt     <= batt_next;
        pos      <= pos_next;
        // only kept frame bytes (3..7) at positions 0..length+1 are copied
        for (int k = FIRST_KEPT; k <= LAST_KEPT; k++) begin
          if (lat && IDX_W'(k) < idx_next) begin
            latched[k] <= (widx == IDX_W'(k)) ? q_op.data : staging[k];
          end
        end
      end
    end
  end

  assign m_tdata = {5'b0, res};

endmodule

@@ hdl/servo_reply_frame_receiver.sv @@
// Top level: config registers, front end queue and deframing back end.
// Each result is registered in the output register after its request passes through the queue.
// Throughput: one request per cycle; the output register and a two-entry
// queue between front and back end let either side stall on its own.
// Reset (rst, synchronous): clears deframer state, latched frame, decoded values,
// and restores the config registers to their defaults; no clearing pass.
module servo_reply_frame_receiver import srfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte
  input  logic        s_tuser,    // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // frame_ready, frame_latched, frame_dropped,
                                  // battery_volt[15:0], servo_position[15:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] header_byte;
  cmd_cfg_t   cmds;
  logic       q_valid;
  op_t        q_op;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte           <= 8'd85;
      cmds.battery_command  <= 8'd15;
      cmds.position_command <= 8'd21;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER:   header_byte           <= cfg_data;
        REG_BATT_CMD: cmds.battery_command  <= cfg_data;
        REG_POS_CMD:  cmds.position_command <= cfg_data;
        default: ;
      endcase
    end
  end

  srfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .header_byte (header_byte),
    .pop         (pop),
    .q_valid     (q_valid),
    .q_op        (q_op)
  );

  srfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .pop      (pop),
    .cmds     (cmds),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_latch_drop_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
    else $error("frame both latched and dropped");

  a_latch_sets_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> m_tdata[0])
    else $error("latched frame without ready flag");

  a_request_queued: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_valid)
    else $error("accepted request missing from queue");

endmodule

@@ tb/servo_reply_frame_receiver_checker.sv @@
`timescale 1ns / 1ps
// Reply checker: watches all channels, predicts each reply of the deframer and compares it.
module servo_reply_frame_receiver_checker import srfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [7:0] DEF_HEADER   = 8'd85;
  localparam logic [7:0] DEF_BATT_CMD = 8'd15;
  localparam logic [7:0] DEF_POS_CMD  = 8'd21;
  // bytes ahead of the counted length: header and length position offset
  localparam logic [IDX_W-1:0] LEAD_BYTES = 4'd2;

  logic [7:0]       header_value;
  cmd_cfg_t         commands;
  logic             in_frame;
  logic [1:0]       headers_seen;
  logic [IDX_W-1:0] frame_len;
  logic [IDX_W-1:0] byte_pos;
  logic [7:0]       staged [MAX_FRAME_BYTES];
  logic [7:0]       latched [MAX_FRAME_BYTES];
  logic             pending;
  logic [15:0]      battery_q;
  logic [15:0]      position_q;
  result_t          expected_replies [$];
  int               replies_seen;

  initial mismatches = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                 input logic [15:0] want_v);
    $display("mismatch at reply %0d, %s: got %h, expected %h", replies_seen, what,
             got_v, want_v);
    mismatches++;
  endtask

  function automatic result_t deframe_step(input logic kind, input logic [7:0] b);
    result_t r;
    r = '0;
    if (kind == REQ_BYTE) begin
      if (!in_frame) begin
        if (b == header_value) begin
          headers_seen = headers_seen + 2'd1;
          if (headers_seen == 2'd2) begin
            headers_seen = '0;
            in_frame = 1'b1;
            byte_pos = 4'd1;
          end
        end else begin
          byte_pos = '0;
          headers_seen = '0;
        end
      end
      if (in_frame) begin
        if (byte_pos < MAX_FRAME_BYTES) staged[byte_pos] = b;
        if (byte_pos == LEN_POS) begin
          if (b < LEN_MIN || b > LEN_MAX) begin
            frame_len = LEN_MIN;
            in_frame = 1'b0;
          end else begin
            frame_len = b[IDX_W-1:0];
          end
        end
        byte_pos = byte_pos + 4'd1;
        if (byte_pos == frame_len + LEAD_BYTES) begin
          if (!pending) begin
            pending = 1'b1;
            for (int i = 0; i < MAX_FRAME_BYTES; i++)
              if (i < byte_pos) latched[i] = staged[i];
            r.frame_latched = 1'b1;
          end else begin
            r.frame_dropped = 1'b1;
          end
          in_frame = 1'b0;
        end
      end
    end else if (pending) begin
      pending = 1'b0;
      if (latched[CMD_POS] == commands.battery_command)
        battery_q = {latched[BATT_HI], latched[BATT_LO]};
      else if (latched[CMD_POS] == commands.position_command)
        position_q = {latched[POS_HI], latched[POS_LO]};
    end
    r.frame_ready = pending;
    r.battery_volt = battery_q;
    r.servo_position = position_q;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (rst) begin
      header_value = DEF_HEADER;
      commands.battery_command = DEF_BATT_CMD;
      commands.position_command = DEF_POS_CMD;
      in_frame = 1'b0;
      headers_seen = '0;
      frame_len = LEN_MIN;
      byte_pos = '0;
      for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
        staged[i] = '0;
        latched[i] = '0;
      end
      pending = 1'b0;
      battery_q = '0;
      position_q = '0;
      expected_replies.delete();
      replies_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADER:   header_value = cfg_data;
          REG_BATT_CMD: commands.battery_command = cfg_data;
          REG_POS_CMD:  commands.position_command = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(result_t)-1:0];
        if (m_tdata[39:$bits(result_t)] !== '0)
          report_mismatch("pad bits", 16'(m_tdata[39:$bits(result_t)]), '0);
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with none expected", got.battery_volt, '0);
        end else begin
          want = expected_replies.pop_front();
          if (got.frame_ready !== want.frame_ready)
            report_mismatch("frame_ready", 16'(got.frame_ready), 16'(want.frame_ready));
          if (got.frame_latched !== want.frame_latched)
            report_mismatch("frame_latched", 16'(got.frame_latched), 16'(want.frame_latched));
          if (got.frame_dropped !== want.frame_dropped)
            report_mismatch("frame_dropped", 16'(got.frame_dropped), 16'(want.frame_dropped));
          if (got.battery_volt !== want.battery_volt)
            report_mismatch("battery_volt", got.battery_volt, want.battery_volt);
          if (got.servo_position !== want.servo_position)
            report_mismatch("servo_position", got.servo_position, want.servo_position);
        end
        replies_seen++;
      end
      if (s_tvalid && s_tready)
        expected_replies.push_back(deframe_step(s_tuser, s_tdata));
    end
    outstanding <= expected_replies.size();
  end

endmodule

@@ tb/servo_reply_frame_receiver_test.sv @@
`timescale 1ns / 1ps
// Testbench top: drives byte and consume requests, config writes, back pressure; gives the verdict.
module servo_reply_frame_receiver_test;
  import srfr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int outstanding;
  int items_sent;
  int stalled_cycles;
  int hold_requests;
  bit quiet_tail;

  logic [7:0] cur_header;
  logic [7:0] cur_batt_cmd;
  logic [7:0] cur_pos_cmd;

  servo_reply_frame_receiver uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  servo_reply_frame_receiver_checker reply_check (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: no handshake on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // reply side back pressure
  initial begin : reply_sink
    int holds_served;
    holds_served = 0;
    forever begin
      if (holds_served != hold_requests) begin
        holds_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic put_request(input logic kind, input logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_consume();
    put_request(REQ_CONSUME, 8'($urandom_range(0, 255)));
  endtask

  // two headers, then the first 'keep' frame bytes starting at the length byte
  task automatic send_frame(input logic [7:0] len_b, input logic [7:0] cmd, input int keep,
                            input logic fixed, input logic [7:0] fill);
    logic [7:0] body [MAX_FRAME_BYTES];
    body[0] = len_b;
    body[1] = cmd;
    for (int i = 2; i < MAX_FRAME_BYTES; i++)
      body[i] = fixed ? fill : 8'($urandom_range(0, 255));
    put_request(REQ_BYTE, cur_header);
    put_request(REQ_BYTE, cur_header);
    for (int i = 0; i < keep; i++) put_request(REQ_BYTE, body[i]);
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 2))
      0: return cur_batt_cmd;
      1: return cur_pos_cmd;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    logic [7:0] len_b;
    pick = $urandom_range(0, 99);
    len_b = 8'($urandom_range(LEN_MIN, LEN_MAX));
    if (pick < 55) begin
      send_frame(len_b, pick_command(), int'(len_b), 1'b0, '0);
      if ($urandom_range(0, 1) == 0) send_consume();
    end else if (pick < 63) begin
      if ($urandom_range(0, 1) == 0) len_b = 8'($urandom_range(0, int'(LEN_MIN) - 1));
      else len_b = 8'($urandom_range(int'(LEN_MAX) + 1, 255));
      send_frame(len_b, pick_command(), int'($urandom_range(1, 4)), 1'b0, '0);
    end else if (pick < 71) begin
      send_frame(len_b, pick_command(), int'($urandom_range(1, int'(len_b) - 1)), 1'b0, '0);
    end else if (pick < 88) begin
      send_consume();
    end else begin
      put_request(REQ_BYTE, ($urandom_range(0, 3) == 0) ? cur_header
                                                         : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) random_item();
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // only with the block drained
  task automatic set_config(input logic [7:0] hdr_v, input logic [7:0] batt_v,
                            input logic [7:0] pos_v);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    write_register(REG_HEADER, hdr_v);
    write_register(REG_BATT_CMD, batt_v);
    write_register(REG_POS_CMD, pos_v);
    cfg_valid <= 1'b0;
    cur_header = hdr_v;
    cur_batt_cmd = batt_v;
    cur_pos_cmd = pos_v;
  endtask

  initial begin : stimulus
    logic [7:0] shared_cmd;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= REQ_BYTE;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_HEADER;
    cfg_data <= '0;
    cur_header = 8'd85;
    cur_batt_cmd = 8'd15;
    cur_pos_cmd = 8'd21;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: consume with nothing pending, full position frame, drop while full,
    // bad length low, short frame decoded from stale latched bytes
    put_request(REQ_CONSUME, 8'hFF);
    send_frame(8'(LEN_MAX), cur_pos_cmd, int'(LEN_MAX), 1'b1, 8'hFF);
    send_frame(8'(LEN_MIN), cur_batt_cmd, int'(LEN_MIN), 1'b1, 8'h00);
    put_request(REQ_CONSUME, 8'h00);
    send_frame(8'd1, cur_batt_cmd, 1, 1'b1, 8'h00);
    send_frame(8'(LEN_MIN), cur_batt_cmd, int'(LEN_MIN), 1'b1, 8'h00);
    put_request(REQ_CONSUME, 8'h00);

    set_config(8'h00, 8'h00, 8'hFF);
    hold_requests <= hold_requests + 1;
    run_random(245);

    set_config(8'hFF, 8'hFF, 8'h00);
    run_random(245);

    // equal command codes: battery decode wins
    shared_cmd = 8'($urandom_range(0, 255));
    set_config(8'($urandom_range(0, 255)), shared_cmd, shared_cmd);
    run_random(245);

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    hold_requests <= hold_requests + 1;
    run_random(245);

    set_config(8'd85, 8'd15, 8'd21);
    quiet_tail <= 1'b1;
    run_random(245);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/srfr_pkg.sv
hdl/srfr_front.sv
hdl/srfr_back.sv
hdl/servo_reply_frame_receiver.sv
tb/servo_reply_frame_receiver_checker.sv
tb/servo_reply_frame_receiver_test.sv
